// ----- design/mbf40_pkg.sv -----
// Shared types, codes and sizes for the 40-bit MBF arithmetic unit.
`default_nettype none

package mbf40_pkg;

   // Depth of the queue between the front end and the execution pipeline.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // The divider retires this many quotient bits in each of its stages.
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_QUO_BITS       = 56;
   localparam int DIV_STAGES         = DIV_QUO_BITS / DIV_BITS_PER_STAGE;

   // Format constants.
   localparam logic [7:0]  EXP_BIAS = 8'd129;
   localparam logic [7:0]  EXP_MAX  = 8'hFF;
   localparam logic [30:0] MANT_MAX = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_MUL    = 3'd2,
      CMD_DIV    = 3'd3,
      CMD_NEG    = 3'd4,
      CMD_CMP    = 3'd5,
      CMD_FROM_INT = 3'd6,
      CMD_TO_INT = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   // Work classes handed from the front end to the execution pipeline.
   typedef enum logic [2:0] {
      KIND_DONE,
      KIND_ADD,
      KIND_MUL,
      KIND_DIV,
      KIND_INT
   } kind_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [39:0]        operand_a;
      logic [39:0]        operand_b;
      logic signed [63:0] int_value;
   } req_type;

   typedef struct packed {
      logic [39:0]        result_value;
      logic signed [63:0] int_result;
      logic               less;
      logic               equal;
      logic               greater;
      logic [1:0]         status;
   } rsp_type;

   // Classified operation. The mag field carries the integer magnitude for
   // conversion from an integer and collects the quotient bits for division.
   typedef struct packed {
      kind_type    kind;
      rsp_type     done;
      logic        sign_a;
      logic        sign_b;
      logic [7:0]  exp_a;
      logic [7:0]  exp_b;
      logic [31:0] sig_a;
      logic [31:0] sig_b;
      logic [63:0] mag;
      logic [32:0] rem;
   } work_type;

endpackage

`default_nettype wire

// ----- design/mbf40_front.sv -----
// Front end: decodes a request word, finishes the simple commands and classifies the rest.
`default_nettype none

module mbf40_front (
   input  mbf40_pkg::req_type  req_word,
   output mbf40_pkg::work_type work_word
);

   always_comb begin
      logic [7:0]  ea, eb, ex;
      logic        sa, sb, sbe, za, zb, sga, sgb, lt, gt;
      logic [30:0] fa, fb;
      logic [38:0] mga, mgb;
      logic [94:0] wide;
      logic [63:0] mag, vu;

      ea   = req_word.operand_a[39:32];
      eb   = req_word.operand_b[39:32];
      sa   = req_word.operand_a[31];
      sb   = req_word.operand_b[31];
      fa   = req_word.operand_a[30:0];
      fb   = req_word.operand_b[30:0];
      za   = (ea == 8'd0);
      zb   = (eb == 8'd0);
      sbe  = sb ^ (req_word.command == mbf40_pkg::CMD_SUB);
      vu   = req_word.int_value;
      ex   = ea - mbf40_pkg::EXP_BIAS;
      wide = '0;
      mag  = '0;

      work_word        = '0;
      work_word.kind   = mbf40_pkg::KIND_DONE;
      work_word.exp_a  = ea;
      work_word.exp_b  = eb;
      work_word.sig_a  = {1'b1, fa};
      work_word.sig_b  = {1'b1, fb};
      work_word.sign_a = sa;
      work_word.sign_b = sbe;

      // Signed comparison keys; every zero encoding reads as plus zero.
      mga = za ? 39'd0 : {ea, fa};
      mgb = zb ? 39'd0 : {eb, fb};
      sga = ~za & sa;
      sgb = ~zb & sb;
      lt  = (sga != sgb) ? sga : (sga ? (mga > mgb) : (mga < mgb));
      gt  = (sga != sgb) ? sgb : (sga ? (mga < mgb) : (mga > mgb));

      case (req_word.command)
         mbf40_pkg::CMD_ADD, mbf40_pkg::CMD_SUB: begin
            // A zero operand or an exact cancellation needs no arithmetic.
            if (za && zb) begin
               work_word.done.result_value = '0;
            end else if (za) begin
               work_word.done.result_value = {eb, sbe, fb};
            end else if (zb) begin
               work_word.done.result_value = req_word.operand_a;
            end else if ({ea, fa} == {eb, fb} && sa != sbe) begin
               work_word.done.result_value = '0;
            end else begin
               work_word.kind = mbf40_pkg::KIND_ADD;
            end
         end
         mbf40_pkg::CMD_MUL: begin
            if (!(za || zb)) begin
               work_word.kind   = mbf40_pkg::KIND_MUL;
               work_word.sign_a = sa ^ sb;
            end
         end
         mbf40_pkg::CMD_DIV: begin
            if (zb) begin
               work_word.done.status = mbf40_pkg::ST_DIV_ZERO;
               if (!za) begin
                  work_word.done.result_value =
                     {mbf40_pkg::EXP_MAX, sa, mbf40_pkg::MANT_MAX};
               end
            end else if (!za) begin
               work_word.kind   = mbf40_pkg::KIND_DIV;
               work_word.sign_a = sa ^ sb;
               work_word.rem    = {2'b01, fa};
            end
         end
         mbf40_pkg::CMD_NEG: begin
            if (!za) begin
               work_word.done.result_value = {ea, ~sa, fa};
            end
         end
         mbf40_pkg::CMD_CMP: begin
            work_word.done.less    = lt;
            work_word.done.greater = gt;
            work_word.done.equal   = !lt && !gt;
         end
         mbf40_pkg::CMD_FROM_INT: begin
            if (vu != 64'd0) begin
               work_word.kind   = mbf40_pkg::KIND_INT;
               work_word.sign_a = vu[63];
               work_word.mag    = vu[63] ? (64'd0 - vu) : vu;
            end
         end
         default: begin
            // Conversion to integer, truncating toward zero.
            if (!za && ea >= mbf40_pkg::EXP_BIAS) begin
               if (ex >= 8'd63) begin
                  if (sa && ex == 8'd63 && fa == 31'd0) begin
                     work_word.done.int_result = {1'b1, 63'd0};
                  end else begin
                     work_word.done.status     = mbf40_pkg::ST_OVERFLOW;
                     work_word.done.int_result = sa ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                  end
               end else begin
                  wide = {63'd0, 1'b1, fa} << ex[5:0];
                  mag  = wide[94:31];
                  work_word.done.int_result = sa ? (64'd0 - mag) : mag;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/mbf40_queue.sv -----
// Short queue of classified words between the front end and the pipeline.
`default_nettype none

module mbf40_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  mbf40_pkg::work_type push_word,
   output logic                full,
   input  wire                 pop,
   output mbf40_pkg::work_type pop_word,
   output logic                empty
);

   mbf40_pkg::work_type                   entry_ff [mbf40_pkg::QUEUE_DEPTH];
   logic [mbf40_pkg::QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mbf40_pkg::QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mbf40_pkg::QUEUE_AW:0]          count_ff, count_in;

   assign full     = (count_ff == (mbf40_pkg::QUEUE_AW+1)'(mbf40_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (mbf40_pkg::QUEUE_AW)'(push);
      rd_ptr_in = rd_ptr_ff + (mbf40_pkg::QUEUE_AW)'(pop);
      count_in  = count_ff + (mbf40_pkg::QUEUE_AW+1)'(push)
                           - (mbf40_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ----- design/mbf40_back.sv -----
// Execution pipeline: divider stages, align, add, leading-zero count, normalize and rounding.
`default_nettype none

module mbf40_back (
   input  wire                 clock,
   input  wire                 reset,
   input  mbf40_pkg::work_type head_word,
   input  wire                 head_empty,
   output logic                head_pop,
   output mbf40_pkg::rsp_type  rsp_word,
   output logic                empty,
   input  wire                 pop
);

   typedef struct packed {
      mbf40_pkg::kind_type kind;
      mbf40_pkg::rsp_type  done;
      logic                sign;
      logic                sub;
      logic [96:0]         x;
      logic [95:0]         y;
      logic                jam;
      logic [11:0]         base;
   } align_type;

   typedef struct packed {
      mbf40_pkg::kind_type kind;
      mbf40_pkg::rsp_type  done;
      logic                sign;
      logic [96:0]         x;
      logic                jam;
      logic [11:0]         base;
      logic [6:0]          lz;
   } norm_type;

   typedef struct packed {
      mbf40_pkg::kind_type kind;
      mbf40_pkg::rsp_type  done;
      logic                sign;
      logic [63:0]         sig;
      logic                sticky;
      logic [11:0]         ex;
   } pack_type;

   // One restoring division step: one quotient bit.
   function automatic mbf40_pkg::work_type div_step(mbf40_pkg::work_type w);
      logic        ge;
      logic [32:0] dd;
      ge     = (w.rem >= {1'b0, w.sig_b});
      dd     = ge ? (w.rem - {1'b0, w.sig_b}) : w.rem;
      w.mag  = {w.mag[62:0], ge};
      w.rem  = {dd[31:0], 1'b0};
      return w;
   endfunction

   // Leading zero count of a nonzero 97-bit word.
   function automatic logic [6:0] lzc97(logic [96:0] x);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 97; i++) begin
         if (x[i]) begin
            n = 7'(96 - i);
         end
      end
      return n;
   endfunction

   logic adv;

   mbf40_pkg::work_type div_ff [mbf40_pkg::DIV_STAGES];
   mbf40_pkg::work_type div_in [mbf40_pkg::DIV_STAGES];
   logic [mbf40_pkg::DIV_STAGES-1:0] div_vld_ff;
   align_type a_ff, a_in;
   norm_type  b_ff, b_in, c_ff, c_in;
   pack_type  n_ff, n_in;
   mbf40_pkg::rsp_type p_ff, p_in;
   logic a_vld_ff, b_vld_ff, c_vld_ff, n_vld_ff, p_vld_ff;

   // The whole pipeline moves when the output register is free or taken.
   assign adv      = !p_vld_ff || pop;
   assign head_pop = adv && !head_empty;
   assign empty    = !p_vld_ff;
   assign rsp_word = p_ff;

   // Divider stages; other words pass through untouched.
   for (genvar s = 0; s < mbf40_pkg::DIV_STAGES; s++) begin : g_div
      always_comb begin
         mbf40_pkg::work_type w;
         w = (s == 0) ? head_word : div_ff[(s == 0) ? 0 : s-1];
         if (w.kind == mbf40_pkg::KIND_DIV) begin
            for (int j = 0; j < mbf40_pkg::DIV_BITS_PER_STAGE; j++) begin
               w = div_step(w);
            end
         end
         div_in[s] = w;
      end
   end

   // Align the addends, form the product, or place the significand.
   always_comb begin
      mbf40_pkg::work_type w;
      logic        a_big;
      logic [7:0]  ebig, esml, d;
      logic [31:0] sbig, ssml;
      logic [191:0] t;
      logic [63:0] prod;
      w     = div_ff[mbf40_pkg::DIV_STAGES-1];
      a_big = ({w.exp_a, w.sig_a} >= {w.exp_b, w.sig_b});
      ebig  = a_big ? w.exp_a : w.exp_b;
      esml  = a_big ? w.exp_b : w.exp_a;
      sbig  = a_big ? w.sig_a : w.sig_b;
      ssml  = a_big ? w.sig_b : w.sig_a;
      d     = ebig - esml;
      t     = {ssml, 160'd0} >> d;
      prod  = w.sig_a * w.sig_b;

      a_in      = '0;
      a_in.kind = w.kind;
      a_in.done = w.done;
      a_in.sign = w.sign_a;
      case (w.kind)
         mbf40_pkg::KIND_ADD: begin
            a_in.sign = a_big ? w.sign_a : w.sign_b;
            a_in.sub  = (w.sign_a != w.sign_b);
            a_in.x    = {1'b0, sbig, 64'd0};
            a_in.y    = t[191:96] | {95'd0, (t[95:0] != '0) || (d >= 8'd192)};
            a_in.base = {4'd0, ebig} - 12'd128;
         end
         mbf40_pkg::KIND_MUL: begin
            a_in.x    = {prod, 33'd0};
            a_in.base = {4'd0, w.exp_a} + {4'd0, w.exp_b} - 12'd257;
         end
         mbf40_pkg::KIND_DIV: begin
            a_in.x    = {w.mag[mbf40_pkg::DIV_QUO_BITS-1:0], 41'd0};
            a_in.jam  = (w.rem != '0);
            a_in.base = {4'd0, w.exp_a} - {4'd0, w.exp_b};
         end
         mbf40_pkg::KIND_INT: begin
            a_in.x    = {w.mag, 33'd0};
            a_in.base = 12'd63;
         end
         default: begin
         end
      endcase
   end

   // Add or subtract the aligned significands.
   always_comb begin
      b_in      = '0;
      b_in.kind = a_ff.kind;
      b_in.done = a_ff.done;
      b_in.sign = a_ff.sign;
      b_in.jam  = a_ff.jam;
      b_in.base = a_ff.base;
      b_in.x    = a_ff.x;
      if (a_ff.kind == mbf40_pkg::KIND_ADD) begin
         b_in.x = a_ff.sub ? (a_ff.x - {1'b0, a_ff.y}) : (a_ff.x + {1'b0, a_ff.y});
      end
   end

   // Count leading zeros.
   always_comb begin
      c_in    = b_ff;
      c_in.lz = lzc97(b_ff.x);
   end

   // Normalize so the leading one sits at the top of a 64-bit significand.
   always_comb begin
      logic [96:0] sh;
      sh          = c_ff.x << c_ff.lz;
      n_in.kind   = c_ff.kind;
      n_in.done   = c_ff.done;
      n_in.sign   = c_ff.sign;
      n_in.sig    = sh[96:33];
      n_in.sticky = (sh[32:0] != '0) || c_ff.jam;
      n_in.ex     = c_ff.base - {5'd0, c_ff.lz};
   end

   // Round to 53 bits (nearest even), then to 32 bits (ties away), and pack.
   always_comb begin
      logic        up;
      logic [53:0] k1;
      logic [52:0] k2;
      logic [32:0] k3;
      logic [31:0] k4;
      logic [11:0] e1, e2, eb;
      up = n_ff.sig[10] && ((n_ff.sig[9:0] != '0) || n_ff.sticky || n_ff.sig[11]);
      k1 = {1'b0, n_ff.sig[63:11]} + {53'd0, up};
      k2 = k1[53] ? k1[53:1] : k1[52:0];
      e1 = n_ff.ex + {11'd0, k1[53]};
      k3 = {1'b0, k2[52:21]} + {32'd0, k2[20]};
      k4 = k3[32] ? k3[32:1] : k3[31:0];
      e2 = e1 + {11'd0, k3[32]};
      eb = e2 + 12'd129;

      p_in = '0;
      if (n_ff.kind == mbf40_pkg::KIND_DONE) begin
         p_in = n_ff.done;
      end else if (!eb[11] && eb > 12'd255) begin
         p_in.status       = mbf40_pkg::ST_OVERFLOW;
         p_in.result_value = {mbf40_pkg::EXP_MAX, n_ff.sign, mbf40_pkg::MANT_MAX};
      end else if (eb[11] || eb == 12'd0) begin
         p_in.status = mbf40_pkg::ST_UNDERFLOW;
      end else begin
         p_in.result_value = {eb[7:0], n_ff.sign, k4[30:0]};
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         n_vld_ff   <= 1'b0;
         p_vld_ff   <= 1'b0;
      end else if (adv) begin
         div_vld_ff <= {div_vld_ff[mbf40_pkg::DIV_STAGES-2:0], !head_empty};
         a_vld_ff   <= div_vld_ff[mbf40_pkg::DIV_STAGES-1];
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         n_vld_ff   <= c_vld_ff;
         p_vld_ff   <= n_vld_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < mbf40_pkg::DIV_STAGES; s++) begin
            div_ff[s] <= div_in[s];
         end
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         n_ff <= n_in;
         p_ff <= p_in;
      end
   end

   // At most one compare flag is ever set.
   assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> $onehot0({p_ff.less, p_ff.equal, p_ff.greater}))
      else $error("more than one compare flag set");

   // A flushed result is always plain zero.
   assert property (@(posedge clock) disable iff (reset)
      (p_vld_ff && p_ff.status == mbf40_pkg::ST_UNDERFLOW) |-> (p_ff.result_value == '0))
      else $error("underflow result is not zero");

   // A stalled pipeline keeps its occupancy.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(div_vld_ff) && $stable(n_vld_ff)))
      else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ----- design/mbf40_float_arith_unit_core.sv -----
// Top level of the 40-bit MBF arithmetic unit.
`default_nettype none

// One request word is accepted per cycle while full is low, and one response
// word comes out per cycle while the receiver pops, in order. The word leaves
// the input queue into the first divider stage and passes 28 divider stages
// that retire two quotient bits each. It then passes the
// align, add, leading-zero count, normalize and rounding stages, and the last of
// these is the output register. Every command runs through the same pipeline, so
// order is kept without tags. A four-entry queue sits between the decoder and
// the pipeline. When the response is not popped, the pipeline holds and the queue
// fills, after which full is raised. There is no state and no configuration;
// reset only empties the queue and the pipeline.
module mbf40_float_arith_unit_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  mbf40_pkg::req_type  req_word,
   output logic                empty,
   input  wire                 pop,
   output mbf40_pkg::rsp_type  rsp_word
);

   mbf40_pkg::work_type front_word;
   mbf40_pkg::work_type head_word;
   logic                head_empty;
   logic                head_pop;
   logic                queue_push;

   assign queue_push = push && !full;

   mbf40_front u_front (
      .req_word  (req_word),
      .work_word (front_word)
   );

   mbf40_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_word (front_word),
      .full      (full),
      .pop       (head_pop),
      .pop_word  (head_word),
      .empty     (head_empty)
   );

   mbf40_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_word  (head_word),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_word   (rsp_word),
      .empty      (empty),
      .pop        (pop)
   );

endmodule

`default_nettype wire

// ----- bench/mbf40_rsp_checker.sv -----
// Response checker for the 40-bit MBF arithmetic unit: predicts and compares every word.
`timescale 1ns / 100ps

module mbf40_rsp_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  wire                full,
   input  mbf40_pkg::req_type req_word,
   input  wire                empty,
   input  wire                pop,
   input  mbf40_pkg::rsp_type rsp_word,
   output int                 fail_count,
   output int                 pending_count
);

   // Predicted responses, oldest first.
   mbf40_pkg::rsp_type expected_rsp[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Prints one line for a mismatch and counts it.
   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Widens an MBF word exactly to binary64 bits.
   function automatic logic [63:0] widen_bits(logic [39:0] w);
      logic [10:0] ef;
      ef = 11'(w[39:32]) + 11'd894;
      if (w[39:32] == 8'd0) return 64'd0;
      return {w[31], ef, w[30:0], 21'd0};
   endfunction

   // Rounds a normalized significand to 53 bits (ties to even), then to 32 (ties away).
   function automatic logic [39:0] pack_mbf(bit neg, int ex, logic [63:0] sig,
                                            inout logic [1:0] st);
      logic [53:0] keep;
      logic [10:0] rem;
      logic [32:0] k2;
      logic [20:0] r2;
      int          biased;
      keep = {1'b0, sig[63:11]};
      rem  = sig[10:0];
      if (rem > 11'h400 || (rem == 11'h400 && keep[0])) keep++;
      if (keep[53]) begin
         keep = keep >> 1;
         ex++;
      end
      k2 = 33'(keep >> 21);
      r2 = keep[20:0];
      if (r2 >= 21'h100000) k2++;
      if (k2[32]) begin
         k2 = k2 >> 1;
         ex++;
      end
      biased = ex + 129;
      if (biased > 255) begin
         st = mbf40_pkg::ST_OVERFLOW;
         return {mbf40_pkg::EXP_MAX, neg, mbf40_pkg::MANT_MAX};
      end
      if (biased < 1) begin
         st = mbf40_pkg::ST_UNDERFLOW;
         return 40'd0;
      end
      return {8'(biased), neg, k2[30:0]};
   endfunction

   // Narrows a binary64 value to MBF.
   function automatic logic [39:0] narrow_real(real d, inout logic [1:0] st);
      logic [63:0] bits;
      bits = $realtobits(d);
      if (bits[62:52] == 11'd0) begin
         if (bits[51:0] != 52'd0) st = mbf40_pkg::ST_UNDERFLOW;
         return 40'd0;
      end
      if (bits[62:52] == 11'h7FF) begin
         st = mbf40_pkg::ST_OVERFLOW;
         return {mbf40_pkg::EXP_MAX, bits[63], mbf40_pkg::MANT_MAX};
      end
      return pack_mbf(bits[63], int'(bits[62:52]) - 1023, {1'b1, bits[51:0], 11'd0}, st);
   endfunction

   // Converts a signed 64-bit integer to MBF.
   function automatic logic [39:0] int_to_mbf(logic [63:0] v, inout logic [1:0] st);
      logic [63:0] mag;
      int          ex;
      mag = v[63] ? -v : v;
      ex  = 63;
      if (mag == 64'd0) return 40'd0;
      while (!mag[63]) begin
         mag = mag << 1;
         ex--;
      end
      return pack_mbf(v[63], ex, mag, st);
   endfunction

   // Truncates an MBF word toward zero into a saturated 64-bit integer.
   function automatic logic [63:0] mbf_truncate(logic [39:0] w, inout logic [1:0] st);
      logic [63:0] sig;
      logic [63:0] mag;
      int          ex;
      if (w[39:32] == 8'd0) return 64'd0;
      ex  = int'(w[39:32]) - 129;
      sig = {32'd0, 1'b1, w[30:0]};
      if (ex < 0) return 64'd0;
      if (ex >= 63) begin
         if (w[31] && ex == 63 && w[30:0] == 31'd0) return 64'h8000_0000_0000_0000;
         st = mbf40_pkg::ST_OVERFLOW;
         return w[31] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      if (ex >= 31) mag = sig << (ex - 31);
      else mag = sig >> (31 - ex);
      return w[31] ? -mag : mag;
   endfunction

   // Computes the response word for one request word.
   function automatic mbf40_pkg::rsp_type predict_rsp(mbf40_pkg::req_type r);
      mbf40_pkg::rsp_type p;
      real                da;
      real                db;
      logic [1:0]         st;
      p  = '0;
      st = mbf40_pkg::ST_OK;
      da = $bitstoreal(widen_bits(r.operand_a));
      db = $bitstoreal(widen_bits(r.operand_b));
      case (mbf40_pkg::cmd_type'(r.command))
         mbf40_pkg::CMD_ADD: p.result_value = narrow_real(da + db, st);
         mbf40_pkg::CMD_SUB: p.result_value = narrow_real(da - db, st);
         mbf40_pkg::CMD_MUL: p.result_value = narrow_real(da * db, st);
         mbf40_pkg::CMD_DIV: begin
            if (r.operand_b[39:32] == 8'd0) begin
               st = mbf40_pkg::ST_DIV_ZERO;
               if (r.operand_a[39:32] != 8'd0)
                  p.result_value = {mbf40_pkg::EXP_MAX, r.operand_a[31], mbf40_pkg::MANT_MAX};
            end else begin
               p.result_value = narrow_real(da / db, st);
            end
         end
         mbf40_pkg::CMD_NEG: p.result_value = narrow_real(-da, st);
         mbf40_pkg::CMD_CMP: begin
            p.less    = da < db;
            p.greater = da > db;
            p.equal   = !p.less && !p.greater;
         end
         mbf40_pkg::CMD_FROM_INT: p.result_value = int_to_mbf(r.int_value, st);
         default: p.int_result = mbf_truncate(r.operand_a, st);
      endcase
      p.status = st;
      return p;
   endfunction

   // Records accepted requests and checks accepted responses.
   always @(posedge clock) begin
      mbf40_pkg::rsp_type want;
      if (!reset) begin
         if (push && !full) expected_rsp.push_back(predict_rsp(req_word));
         if (pop && !empty) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected word", 64'(rsp_word.result_value), 64'd0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_word.result_value !== want.result_value)
                  report("result_value", 64'(rsp_word.result_value), 64'(want.result_value));
               if (rsp_word.int_result !== want.int_result)
                  report("int_result", rsp_word.int_result, want.int_result);
               if (rsp_word.less !== want.less)
                  report("less", 64'(rsp_word.less), 64'(want.less));
               if (rsp_word.equal !== want.equal)
                  report("equal", 64'(rsp_word.equal), 64'(want.equal));
               if (rsp_word.greater !== want.greater)
                  report("greater", 64'(rsp_word.greater), 64'(want.greater));
               if (rsp_word.status !== want.status)
                  report("status", 64'(rsp_word.status), 64'(want.status));
            end
         end
         pending_count = expected_rsp.size();
      end
   end

endmodule

// ----- bench/tb_mbf40_float_arith_unit_core.sv -----
// Testbench top for the 40-bit MBF arithmetic unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_mbf40_float_arith_unit_core;

   localparam int RANDOM_WORDS = 1250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   logic               clock    = 1'b0;
   logic               reset    = 1'b1;
   logic               push     = 1'b0;
   logic               pop      = 1'b0;
   mbf40_pkg::req_type req_word = '0;
   logic               full;
   logic               empty;
   mbf40_pkg::rsp_type rsp_word;
   int                 fail_count;
   int                 pending_count;

   int      send_idle_pct = 35;
   int      recv_idle_pct = 75;
   bit      hold_phase    = 1'b0;
   int      cycle_count   = 0;

   mbf40_float_arith_unit_core uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );

   mbf40_rsp_checker u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Cycle limit guards against a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: random pop idling, plus one long hold-off when asked for.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_phase && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one word, idling at random first, and waits until it is taken.
   task automatic send_word(input mbf40_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
   endtask

   task automatic send_op(input mbf40_pkg::cmd_type c, input logic [39:0] a,
                          input logic [39:0] b, input logic [63:0] iv);
      mbf40_pkg::req_type w;
      w.command   = c;
      w.operand_a = a;
      w.operand_b = b;
      w.int_value = iv;
      send_word(w);
   endtask

   // Random MBF word with exponents weighted toward the edges, the bias and near_exp.
   function automatic logic [39:0] rand_mbf(logic [7:0] near_exp);
      logic [7:0]  e;
      logic [31:0] low;
      low = $urandom;
      case ($urandom_range(9))
         0:       e = 8'd0;
         1:       e = 8'($urandom_range(1, 4));
         2:       e = 8'($urandom_range(251, 255));
         3, 4:    e = near_exp + 8'($urandom_range(6)) - 8'd3;
         5:       e = 8'($urandom_range(120, 140));
         default: e = 8'($urandom);
      endcase
      if ($urandom_range(7) == 0)
         low[30:0] = ($urandom_range(1)) ? 31'd0 : mbf40_pkg::MANT_MAX;
      return {e, low};
   endfunction

   function automatic logic [63:0] rand_int();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0:       v = v >> $urandom_range(63);
         1:       v = v[63] ? ~(v >> $urandom_range(63)) : (v >> $urandom_range(63));
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_random();
      mbf40_pkg::cmd_type c;
      logic [39:0]        a;
      logic [39:0]        b;
      c = mbf40_pkg::cmd_type'($urandom_range(7));
      a = rand_mbf(8'($urandom));
      b = rand_mbf(a[39:32]);
      // Conversions to integer mostly use exponents that land in range.
      if (c == mbf40_pkg::CMD_TO_INT && $urandom_range(3) != 0)
         a[39:32] = 8'($urandom_range(120, 194));
      // Operands of equal magnitude, with the sign flipped at random, exercise cancellation and equality.
      if ($urandom_range(15) == 0) b = a ^ {8'd0, 1'($urandom_range(1)), 31'd0};
      send_op(c, a, b, rand_int());
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: extremes and every special case.
      send_op(mbf40_pkg::CMD_ADD, 40'hFF_7FFF_FFFF, 40'hFF_7FFF_FFFF, 64'd0);
      send_op(mbf40_pkg::CMD_SUB, 40'hFF_FFFF_FFFF, 40'hFF_7FFF_FFFF, 64'd0);
      send_op(mbf40_pkg::CMD_SUB, 40'h81_1234_5678, 40'h81_1234_5678, 64'd0);
      send_op(mbf40_pkg::CMD_MUL, 40'h01_0000_0000, 40'h01_8000_0001, 64'd0);
      send_op(mbf40_pkg::CMD_MUL, 40'hFF_0000_0000, 40'hFF_0000_0000, 64'd0);
      send_op(mbf40_pkg::CMD_MUL, 40'h81_7FFF_FFFF, 40'h81_7FFF_FFFF, 64'd0);
      send_op(mbf40_pkg::CMD_DIV, 40'h90_8000_0000, 40'h00_1234_5678, 64'd0);
      send_op(mbf40_pkg::CMD_DIV, 40'h00_FFFF_FFFF, 40'h00_0000_0000, 64'd0);
      send_op(mbf40_pkg::CMD_DIV, 40'h01_0000_0000, 40'hFF_7FFF_FFFF, 64'd0);
      send_op(mbf40_pkg::CMD_DIV, 40'h82_0000_0000, 40'h82_4000_0000, 64'd0);
      send_op(mbf40_pkg::CMD_NEG, 40'h00_FFFF_FFFF, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_NEG, 40'hFF_FFFF_FFFF, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_CMP, 40'h00_8000_0001, 40'h00_0000_0000, 64'd0);
      send_op(mbf40_pkg::CMD_CMP, 40'h81_8000_0000, 40'h81_0000_0000, 64'd0);
      send_op(mbf40_pkg::CMD_CMP, 40'h82_0000_0000, 40'h81_7FFF_FFFF, 64'd0);
      send_op(mbf40_pkg::CMD_FROM_INT, 40'd0, 40'd0, 64'h8000_0000_0000_0000);
      send_op(mbf40_pkg::CMD_FROM_INT, 40'd0, 40'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_op(mbf40_pkg::CMD_FROM_INT, 40'd0, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_FROM_INT, 40'd0, 40'd0, 64'h0000_0001_0000_0001);
      send_op(mbf40_pkg::CMD_FROM_INT, 40'd0, 40'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(mbf40_pkg::CMD_TO_INT, 40'hC0_8000_0000, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_TO_INT, 40'hC0_0000_0000, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_TO_INT, 40'hC0_8000_0001, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_TO_INT, 40'h80_FFFF_FFFF, 40'd0, 64'd0);
      send_op(mbf40_pkg::CMD_TO_INT, 40'hBF_FFFF_FFFF, 40'd0, 64'd0);

      // Random words in three flow-control phases; the last one holds pop off once.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) begin
            send_idle_pct = 75;
            recv_idle_pct = 35;
         end else if (i == 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_phase    = 1'b1;
         end
         send_random();
      end
      push <= 1'b0;

      // Drain, then let the pipeline settle.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
